FILE: sv/wavetable_tone_generator_unit_assert.svh
// ----------------------------------------------------------------------------
// Wavetable tone generator assertion macros
// Shared concurrent assertion forms for the tone generator checker. Each form
// samples on the rising clock edge and is disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_TONE_GENERATOR_UNIT_ASSERT_SVH
`define WAVETABLE_TONE_GENERATOR_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define WTG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wavetable tone generator check failed");

// Consequent checked in the cycle after the antecedent.
`define WTG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wavetable tone generator check failed");

`endif

FILE: sv/wtg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavetable tone generator package
// Field widths, waveform codes, register indexes and the fixed constants
// used to build the waveform tables.
// ----------------------------------------------------------------------------
package wtg_pkg;

  // Widths fixed by the register fields.
  localparam int SEL_W  = 3;
  localparam int STEP_W = 7;

  // Waveform selection codes; codes 5 to 7 mean silence.
  typedef enum logic [SEL_W-1:0] {
    WAVE_SINE     = 3'd0,
    WAVE_SQUARE   = 3'd1,
    WAVE_SAWTOOTH = 3'd2,
    WAVE_TRIANGLE = 3'd3,
    WAVE_DUAL     = 3'd4
  } wave_sel_t;

  // Register indexes, decoded from address bit 2.
  localparam logic REG_WAVE_SELECT = 1'b0;
  localparam logic REG_OCTAVE_STEP = 1'b1;

  // Fixed point constants for the sine series in Q2.30.
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [1:6] = '{64'd6, 64'd20, 64'd42,
                                                   64'd72, 64'd110, 64'd156};

  // Dual bass lead: (123*sq + 16*(k mod 42)) / 820, rounded.
  localparam longint unsigned LEAD_PERIOD = 64'd42;
  localparam longint unsigned LEAD_STEP   = 64'd16;
  localparam longint unsigned BASS_NUM    = 64'd123;
  localparam longint unsigned DUAL_DEN    = 64'd820;
  localparam longint unsigned DUAL_HALF   = 64'd410;

  // A decaying level is flushed once level * FLUSH_SCALE < 2^SAMPLE_BITS.
  localparam longint unsigned FLUSH_SCALE = 64'd2000000;

endpackage

FILE: sv/wtg_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavetable tone generator waveform tables
// Five constant waveform tables built at elaboration, read at the current
// phase, with the selected waveform and the sine entry as outputs.
// ----------------------------------------------------------------------------
module wtg_rom #(
  parameter int TABLE_DEPTH = 128,
  parameter int SAMPLE_BITS = 16,
  parameter int PHASE_W     = 7
) (
  input  logic [wtg_pkg::SEL_W-1:0] wave_sel,
  input  logic [PHASE_W-1:0]        phase,
  output logic [SAMPLE_BITS-1:0]    wave_value,
  output logic [SAMPLE_BITS-1:0]    sine_value
);
  import wtg_pkg::*;

  localparam longint unsigned DEPTH    = longint'(TABLE_DEPTH);
  localparam longint unsigned DUTY_MAX = (64'd1 << SAMPLE_BITS) - 64'd1;

  logic [SAMPLE_BITS-1:0] sine_rom   [TABLE_DEPTH];
  logic [SAMPLE_BITS-1:0] square_rom [TABLE_DEPTH];
  logic [SAMPLE_BITS-1:0] saw_rom    [TABLE_DEPTH];
  logic [SAMPLE_BITS-1:0] tri_rom    [TABLE_DEPTH];
  logic [SAMPLE_BITS-1:0] dual_rom   [TABLE_DEPTH];

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_entry
    localparam longint unsigned KK   = longint'(k);
    localparam longint unsigned N4   = 64'd4 * KK;
    localparam longint unsigned QUAD = (N4 / DEPTH) & 64'd3;
    localparam longint unsigned REM  = N4 % DEPTH;
    localparam longint unsigned M    = QUAD[0] ? DEPTH - REM : REM;

    // Quarter sine by a seven term series with truncating products.
    localparam longint unsigned X  = (PI_HALF_Q30 * M) / DEPTH;
    localparam longint unsigned X2 = (X * X) >> 30;
    localparam longint unsigned T1 = ((X * X2) >> 30) / TAYLOR_DIV[1];
    localparam longint unsigned T2 = ((T1 * X2) >> 30) / TAYLOR_DIV[2];
    localparam longint unsigned T3 = ((T2 * X2) >> 30) / TAYLOR_DIV[3];
    localparam longint unsigned T4 = ((T3 * X2) >> 30) / TAYLOR_DIV[4];
    localparam longint unsigned T5 = ((T4 * X2) >> 30) / TAYLOR_DIV[5];
    localparam longint unsigned T6 = ((T5 * X2) >> 30) / TAYLOR_DIV[6];
    localparam longint unsigned SUM = X - T1 + T2 - T3 + T4 - T5 + T6;
    localparam longint unsigned S   = SUM > ONE_Q30 ? ONE_Q30 : SUM;
    localparam longint unsigned SV0 = QUAD < 64'd2 ? ONE_Q30 + S : ONE_Q30 - S;
    localparam longint unsigned SV1 =
      (SV0 + (64'd1 << (30 - SAMPLE_BITS))) >> (31 - SAMPLE_BITS);
    localparam longint unsigned SINE_V = SV1 > DUTY_MAX ? DUTY_MAX : SV1;

    // Square is high over the first half, except at index zero.
    localparam bit SQ = (k != 0) && (2 * k < TABLE_DEPTH);
    localparam longint unsigned SQUARE_V = SQ ? (64'd3 << (SAMPLE_BITS - 2)) : 64'd0;

    localparam longint unsigned SAW0  = (KK << SAMPLE_BITS) / DEPTH;
    localparam longint unsigned SAW_V = SAW0 > DUTY_MAX ? DUTY_MAX : SAW0;

    localparam longint unsigned TNUM = QUAD < 64'd2 ? DEPTH + M : DEPTH - M;
    localparam longint unsigned TRI0 = ((TNUM << SAMPLE_BITS) + DEPTH) / (64'd2 * DEPTH);
    localparam longint unsigned TRI_V = TRI0 > DUTY_MAX ? DUTY_MAX : TRI0;

    localparam longint unsigned DNUM =
      (SQ ? BASS_NUM : 64'd0) + LEAD_STEP * (KK % LEAD_PERIOD);
    localparam longint unsigned DUAL0 = ((DNUM << SAMPLE_BITS) + DUAL_HALF) / DUAL_DEN;
    localparam longint unsigned DUAL_V = DUAL0 > DUTY_MAX ? DUTY_MAX : DUAL0;

    assign sine_rom[k]   = SINE_V[SAMPLE_BITS-1:0];
    assign square_rom[k] = SQUARE_V[SAMPLE_BITS-1:0];
    assign saw_rom[k]    = SAW_V[SAMPLE_BITS-1:0];
    assign tri_rom[k]    = TRI_V[SAMPLE_BITS-1:0];
    assign dual_rom[k]   = DUAL_V[SAMPLE_BITS-1:0];
  end

  assign sine_value = sine_rom[phase];

  always_comb begin
    case (wave_sel)
      WAVE_SINE:     wave_value = sine_rom[phase];
      WAVE_SQUARE:   wave_value = square_rom[phase];
      WAVE_SAWTOOTH: wave_value = saw_rom[phase];
      WAVE_TRIANGLE: wave_value = tri_rom[phase];
      WAVE_DUAL:     wave_value = dual_rom[phase];
      default:       wave_value = '0;
    endcase
  end

endmodule

FILE: sv/wtg_phase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavetable tone generator phase and decay state
// Holds the phase accumulator and the decay level, forms the duty value of
// the current tick and advances the state when a tick is taken.
// ----------------------------------------------------------------------------
module wtg_phase #(
  parameter int TABLE_DEPTH = 128,
  parameter int SAMPLE_BITS = 16,
  parameter int PHASE_W     = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       tick_fire,
  input  logic [wtg_pkg::STEP_W-1:0] octave_step,
  input  logic [SAMPLE_BITS-1:0]     wave_value,
  input  logic [SAMPLE_BITS-1:0]     sine_value,
  output logic [PHASE_W-1:0]         phase,
  output logic [SAMPLE_BITS-1:0]     duty
);
  import wtg_pkg::*;

  localparam longint unsigned FLUSH_LIMIT =
    ((64'd1 << SAMPLE_BITS) + FLUSH_SCALE - 64'd1) / FLUSH_SCALE;

  logic [PHASE_W-1:0]     phase_r, phase_nxt;
  logic [SAMPLE_BITS-1:0] decay_r, decay_nxt;
  logic [PHASE_W-1:0]     step_mod_tbl [2**STEP_W];
  logic [PHASE_W-1:0]     step_mod;
  logic [PHASE_W:0]       phase_sum;
  logic [PHASE_W-1:0]     phase_adv;
  logic [SAMPLE_BITS-1:0] halved;
  logic [SAMPLE_BITS-1:0] faded;
  logic                   silent;
  logic                   latch;

  // Step reduced modulo the table depth, so one wrap check suffices.
  for (genvar s = 0; s < 2**STEP_W; s++) begin : g_step
    assign step_mod_tbl[s] = PHASE_W'(s % TABLE_DEPTH);
  end

  assign step_mod  = step_mod_tbl[octave_step];
  assign phase_sum = {1'b0, phase_r} + {1'b0, step_mod};
  assign phase_adv = (phase_sum >= (PHASE_W + 1)'(TABLE_DEPTH))
                   ? PHASE_W'(phase_sum - (PHASE_W + 1)'(TABLE_DEPTH))
                   : phase_sum[PHASE_W-1:0];

  assign halved = decay_r >> 1;
  assign faded  = ({{(64 - SAMPLE_BITS){1'b0}}, halved} < FLUSH_LIMIT) ? '0 : halved;

  assign silent = (octave_step == '0);
  assign latch  = silent && (phase_r != '0);

  assign phase = phase_r;
  assign duty  = !silent ? wave_value : (latch ? sine_value : faded);

  always_comb begin
    phase_nxt = phase_r;
    decay_nxt = decay_r;
    if (tick_fire) begin
      if (silent) begin
        phase_nxt = '0;
        decay_nxt = latch ? sine_value : faded;
      end else begin
        phase_nxt = phase_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      decay_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      decay_r <= decay_nxt;
    end
  end

endmodule

FILE: sv/wavetable_tone_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavetable tone generator
// Wavetable oscillator giving one PWM duty value per sample tick from one of
// five waveform tables, with a fade-out when the step is zero.
// ----------------------------------------------------------------------------
// Each accepted transaction whose sample_tick bit is set yields one result
// transaction carrying the duty level (unsigned Q0.SAMPLE_BITS) and the table
// index used for it; a transaction with sample_tick clear is taken and yields
// nothing. One transaction is accepted per clock unless stalled, and its result
// is registered: the table lookup, the output mux and the phase update are
// combinational, and the phase and decay registers close the only loops. A
// two-entry output buffer (result register plus skid register) lets the input
// keep moving while a result waits; in_stall rises only when both entries are
// full. With octave_step at zero, the first tick at a nonzero phase latches the
// sine entry at that phase and returns the phase to zero; later ticks halve the
// level down to zero. Registers sit at byte 0 (wave_select) and byte 4
// (octave_step) and should be written only while no transaction is in flight.
module wavetable_tone_generator_unit #(
  parameter int TABLE_DEPTH = 128,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_sample_tick,
  // Result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] out_duty_level,
  output logic [$clog2(TABLE_DEPTH)-1:0] out_phase_out,
  // Configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import wtg_pkg::*;

  localparam int PHASE_W = $clog2(TABLE_DEPTH);

  // Configuration registers.
  logic [SEL_W-1:0]  wave_select_r;
  logic [STEP_W-1:0] octave_step_r;
  logic              cfg_write;
  logic              cfg_reg;

  // Datapath between the state and the output buffer.
  logic                   in_fire;
  logic                   tick_fire;
  logic                   out_fire;
  logic [PHASE_W-1:0]     phase;
  logic [SAMPLE_BITS-1:0] duty;
  logic [SAMPLE_BITS-1:0] wave_value;
  logic [SAMPLE_BITS-1:0] sine_value;

  // Output buffer: result register and skid register.
  logic                   out_valid_r, out_valid_nxt;
  logic                   skid_valid_r, skid_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_duty_r;
  logic [PHASE_W-1:0]     out_phase_r;
  logic [SAMPLE_BITS-1:0] skid_duty_r;
  logic [PHASE_W-1:0]     skid_phase_r;

  // The register is selected by address bit 2; the low bits are ignored.
  assign pready    = 1'b1;
  assign cfg_reg   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_reg)
      REG_WAVE_SELECT: prdata = {{(32 - SEL_W){1'b0}}, wave_select_r};
      REG_OCTAVE_STEP: prdata = {{(32 - STEP_W){1'b0}}, octave_step_r};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_select_r <= WAVE_SINE;
      octave_step_r <= STEP_W'(1);
    end else if (cfg_write) begin
      if (cfg_reg == REG_WAVE_SELECT) begin
        wave_select_r <= pwdata[SEL_W-1:0];
      end else begin
        octave_step_r <= pwdata[STEP_W-1:0];
      end
    end
  end

  // The skid register being full is the only reason to hold off the input,
  // and it is a register, so in_stall never follows out_stall in the same cycle.
  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !in_stall;
  assign tick_fire = in_fire && in_sample_tick;
  assign out_fire  = out_valid_r && !out_stall;

  wtg_rom #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .PHASE_W     (PHASE_W)
  ) u_rom (
    .wave_sel   (wave_select_r),
    .phase      (phase),
    .wave_value (wave_value),
    .sine_value (sine_value)
  );

  wtg_phase #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .PHASE_W     (PHASE_W)
  ) u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_fire   (tick_fire),
    .octave_step (octave_step_r),
    .wave_value  (wave_value),
    .sine_value  (sine_value),
    .phase       (phase),
    .duty        (duty)
  );

  // When the result register is free (empty or being taken) it loads the
  // skid entry first, else the new result. When it is held, a new result
  // goes to the skid register. The skid is never full while an input is taken.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = tick_fire;
      end
    end else if (tick_fire) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_duty_r  <= skid_duty_r;
        out_phase_r <= skid_phase_r;
      end else if (tick_fire) begin
        out_duty_r  <= duty;
        out_phase_r <= phase;
      end
    end else if (tick_fire) begin
      skid_duty_r  <= duty;
      skid_phase_r <= phase;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_duty_level = out_duty_r;
  assign out_phase_out  = out_phase_r;

endmodule

FILE: sv/wtg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavetable tone generator port checker
// Watches the channel ports of the tone generator and checks the buffering
// and handshake behavior over time.
// ----------------------------------------------------------------------------
`include "wavetable_tone_generator_unit_assert.svh"

module wtg_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic in_sample_tick,
  input logic out_valid,
  input logic out_stall
);

  // A held result stays offered until it is taken.
  `WTG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // The input is held off only while a result is waiting in front of it.
  `WTG_ASSERT_SAME(a_stall_needs_result, in_stall, out_valid)

  // A tick taken into an empty buffer shows up as a result next cycle.
  `WTG_ASSERT_NEXT(a_tick_to_result,
                   in_valid && !in_stall && in_sample_tick && !out_valid, out_valid)

  // Once the result is taken, the skid entry drains and the input opens.
  `WTG_ASSERT_NEXT(a_skid_drains, in_stall && !out_stall, !in_stall)

endmodule

bind wavetable_tone_generator_unit wtg_checker u_wtg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_sample_tick (in_sample_tick),
  .out_valid      (out_valid),
  .out_stall      (out_stall)
);
